// ===== rtl/core/spimt_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI mode-3 transaction master package
// Shared types, codes and timing constants of the serial engine.
// ----------------------------------------------------------------------------
package spimt_pkg;

  // Timing of the serial frame, in ticks
  localparam logic [7:0] HALF_TICKS  = 8'd1;
  localparam logic [7:0] GUARD_TICKS = 8'd1;

  // Command codes carried by each request
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_RESET  = 3'd1;
  localparam logic [2:0] ACT_WRITE1 = 3'd2;
  localparam logic [2:0] ACT_WRITE2 = 3'd3;
  localparam logic [2:0] ACT_READ1  = 3'd4;
  localparam logic [2:0] ACT_READ2  = 3'd5;
  localparam logic [2:0] ACT_READ3  = 3'd6;

  // Configuration register indexes
  localparam logic REG_SELECTED_CHIP = 1'b0;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_LOW   = 6'b000100,
    PH_HIGH  = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        miso;
  } item_t;

  typedef struct packed {
    logic        rejected;
    logic [23:0] read_data;
    logic        done_res;
    logic        busy_res;
    logic        cs1_n;
    logic        cs0_n;
    logic        mosi;
    logic        sclk;
  } res_t;

endpackage

// ===== rtl/core/spimt_engine.sv =====
// ----------------------------------------------------------------------------
// SPI mode-3 serial engine
// Holds the frame state and advances it by one tick per step.
// ----------------------------------------------------------------------------
module spimt_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  spimt_pkg::item_t item,
  input  logic           selected_chip,
  output logic           idle,
  output spimt_pkg::res_t res
);

  spimt_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [5:0]  bits_r, bits_nxt;
  logic [31:0] oshift_r, oshift_nxt;
  logic [23:0] ishift_r, ishift_nxt;
  logic [4:0]  rbits_r, rbits_nxt;
  logic        sclk_r, sclk_nxt;
  logic        mosi_r, mosi_nxt;
  logic        lwr_r, lwr_nxt;

  logic        cmd;
  logic        cs_low;
  logic        done;
  logic        busy;
  logic [23:0] rdata;
  logic [7:0]  tick_inc;

  assign cmd  = (item.action >= spimt_pkg::ACT_RESET) && (item.action <= spimt_pkg::ACT_READ3);
  assign idle = (phase_r == spimt_pkg::PH_IDLE);

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bits_nxt   = bits_r;
    oshift_nxt = oshift_r;
    ishift_nxt = ishift_r;
    rbits_nxt  = rbits_r;
    sclk_nxt   = sclk_r;
    mosi_nxt   = mosi_r;
    lwr_nxt    = lwr_r;
    cs_low     = 1'b1;
    done       = 1'b0;
    busy       = 1'b1;
    rdata      = '0;

    // Start a frame on a command seen while idle
    if (idle && cmd) begin
      phase_nxt  = spimt_pkg::PH_LEAD;
      tick_nxt   = '0;
      ishift_nxt = '0;
      rbits_nxt  = '0;
      lwr_nxt    = 1'b0;
      case (item.action)
        spimt_pkg::ACT_RESET: begin
          oshift_nxt = '1;
          bits_nxt   = 6'd32;
        end
        spimt_pkg::ACT_WRITE1: begin
          oshift_nxt = {item.reg_addr, item.write_data[7:0], 16'h0000};
          bits_nxt   = 6'd16;
        end
        spimt_pkg::ACT_WRITE2: begin
          oshift_nxt = {item.reg_addr, item.write_data, 8'h00};
          bits_nxt   = 6'd24;
        end
        spimt_pkg::ACT_READ1: begin
          oshift_nxt = {item.reg_addr, 24'h000000};
          bits_nxt   = 6'd8;
          rbits_nxt  = 5'd8;
          lwr_nxt    = 1'b1;
        end
        spimt_pkg::ACT_READ2: begin
          oshift_nxt = {item.reg_addr, 24'h000000};
          bits_nxt   = 6'd8;
          rbits_nxt  = 5'd16;
          lwr_nxt    = 1'b1;
        end
        default: begin
          oshift_nxt = {item.reg_addr, 24'h000000};
          bits_nxt   = 6'd8;
          rbits_nxt  = 5'd24;
          lwr_nxt    = 1'b1;
        end
      endcase
    end

    tick_inc = tick_nxt + 8'd1;

    case (phase_nxt)
      spimt_pkg::PH_LEAD: begin
        sclk_nxt = 1'b1;
        tick_nxt = tick_inc;
        if (tick_inc >= spimt_pkg::GUARD_TICKS) begin
          tick_nxt  = '0;
          phase_nxt = spimt_pkg::PH_LOW;
        end
      end
      spimt_pkg::PH_LOW: begin
        sclk_nxt = 1'b0;
        if (tick_nxt == 8'd0 && bits_nxt != 6'd0) begin
          mosi_nxt   = oshift_nxt[31];
          oshift_nxt = {oshift_nxt[30:0], 1'b0};
        end
        tick_nxt = tick_inc;
        if (tick_inc >= spimt_pkg::HALF_TICKS) begin
          tick_nxt  = '0;
          phase_nxt = spimt_pkg::PH_HIGH;
        end
      end
      spimt_pkg::PH_HIGH: begin
        sclk_nxt = 1'b1;
        tick_nxt = tick_inc;
        if (tick_inc >= spimt_pkg::HALF_TICKS) begin
          tick_nxt = '0;
          if (bits_nxt != 6'd0) begin
            bits_nxt = bits_nxt - 6'd1;
          end else if (rbits_nxt != 5'd0) begin
            rbits_nxt  = rbits_nxt - 5'd1;
            ishift_nxt = {ishift_nxt[22:0], item.miso};
          end
          if (bits_nxt == 6'd0 && rbits_nxt == 5'd0) begin
            phase_nxt = spimt_pkg::PH_TRAIL;
          end else begin
            phase_nxt = spimt_pkg::PH_LOW;
          end
        end
      end
      spimt_pkg::PH_TRAIL: begin
        sclk_nxt = 1'b1;
        tick_nxt = tick_inc;
        if (tick_inc >= spimt_pkg::GUARD_TICKS) begin
          tick_nxt  = '0;
          phase_nxt = spimt_pkg::PH_DONE;
        end
      end
      spimt_pkg::PH_DONE: begin
        sclk_nxt  = 1'b1;
        cs_low    = 1'b0;
        done      = 1'b1;
        rdata     = lwr_nxt ? ishift_nxt : 24'h000000;
        phase_nxt = spimt_pkg::PH_IDLE;
        tick_nxt  = '0;
      end
      default: begin
        sclk_nxt  = 1'b1;
        cs_low    = 1'b0;
        busy      = 1'b0;
        phase_nxt = spimt_pkg::PH_IDLE;
      end
    endcase

    res.sclk      = sclk_nxt;
    res.mosi      = mosi_nxt;
    res.cs0_n     = !(cs_low && !selected_chip);
    res.cs1_n     = !(cs_low && selected_chip);
    res.busy_res  = busy;
    res.done_res  = done;
    res.read_data = rdata;
    res.rejected  = cmd && !idle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= spimt_pkg::PH_IDLE;
      tick_r   <= '0;
      bits_r   <= '0;
      oshift_r <= '0;
      ishift_r <= '0;
      rbits_r  <= '0;
      sclk_r   <= 1'b1;
      mosi_r   <= 1'b0;
      lwr_r    <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bits_r   <= bits_nxt;
      oshift_r <= oshift_nxt;
      ishift_r <= ishift_nxt;
      rbits_r  <= rbits_nxt;
      sclk_r   <= sclk_nxt;
      mosi_r   <= mosi_nxt;
      lwr_r    <= lwr_nxt;
    end
  end

endmodule

// ===== rtl/core/spi_mode3_transaction_master.sv =====
// ----------------------------------------------------------------------------
// SPI mode-3 transaction master
// Tick-driven SPI master with reset, write and read transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the in_ stream is one timing tick of the serial engine.
//   in_tuser carries the command (tick only, reset, write one/two, read 1..3
//   bytes); in_tdata carries the register byte, write data and sampled miso.
//   Every request produces exactly one response on the out_ stream with the
//   line levels for that tick (sclk, mosi, both chip selects), busy, a done
//   pulse with the bytes read, and a flag for a command refused while busy.
//   A request passes through the input register and then the response
//   register. One request is taken every cycle unless the receiver stalls;
//   a single pass of the tick logic per tick keeps the rate at one.
//   When the receiver stalls, the response register holds and the input
//   register fills, after which in_tready drops until out_tready returns.
//   The APB port holds selected_chip at address 0; a write is taken only
//   while no frame is in progress. Reset clears both registers, returns the
//   engine to idle with sclk high and selects chip select zero.
// ----------------------------------------------------------------------------
module spi_mode3_transaction_master (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] reg_addr, [23:8] write_data, [24] miso
  input  logic [2:0]  in_tuser,   // [2:0] action
  // Response stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] sclk, [1] mosi, [2] cs0_n, [3] cs1_n,
                                  // [4] busy_res, [5] done_res,
                                  // [29:6] read_data, [30] rejected
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              s1_valid_r, s1_valid_nxt;
  spimt_pkg::item_t  s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  spimt_pkg::res_t   out_res_r;
  spimt_pkg::res_t   res;
  logic              adv;
  logic              step;
  logic              in_acc;
  logic              eng_idle;
  logic              sel_chip_r;
  logic              cfg_wr;

  // Advance the pipe whenever the response register is free or draining
  assign adv       = !out_valid_r || out_tready;
  assign step      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.action     <= in_tuser;
      s1_item_r.reg_addr   <= in_tdata[7:0];
      s1_item_r.write_data <= in_tdata[23:8];
      s1_item_r.miso       <= in_tdata[24];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  spimt_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (s1_item_r),
    .selected_chip (sel_chip_r),
    .idle          (eng_idle),
    .res           (res)
  );

  // Configuration: drop writes while a frame is in progress
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == spimt_pkg::REG_SELECTED_CHIP)
                      && (cfg_paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_chip_r <= 1'b0;
    end else if (cfg_wr && eng_idle) begin
      sel_chip_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == spimt_pkg::REG_SELECTED_CHIP)
                      ? {31'h00000000, sel_chip_r} : 32'h00000000;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the SPI mode-3 transaction master
// Streams timing ticks with commands into the engine, predicts the line
// levels, busy, done and read bytes of every tick, and checks each response
// field by field. Both chip selects are exercised through the APB register.
// ----------------------------------------------------------------------------
module tb;
  import spimt_pkg::*;

  localparam logic [2:0] CHIP_ADDR = 3'(4 * REG_SELECTED_CHIP);
  localparam int LONG_HOLD_OFF = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [7:0] reg_addr, [23:8] write_data, [24] miso
  logic [2:0]  in_tuser = '0;   // [2:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [0] sclk, [1] mosi, [2] cs0_n, [3] cs1_n,
                                // [4] busy_res, [5] done_res,
                                // [29:6] read_data, [30] rejected
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  spi_mode3_transaction_master i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests waiting to be offered, and line levels expected back in order
  item_t pending_ticks[$];
  res_t  expected_lines[$];
  int    mismatches = 0;
  int    responses = 0;
  int    send_gap_pct = 0;
  int    recv_stall_pct = 0;

  // --------------------------------------------------------------------------
  // Shadow of the serial engine: its own state and the chip select choice.
  // --------------------------------------------------------------------------
  phase_t      eng_phase = PH_IDLE;
  logic [7:0]  tick_cnt = '0;
  logic [5:0]  bits_left = '0;
  logic [31:0] tx_shift = '0;
  logic [23:0] rx_shift = '0;
  logic [4:0]  read_left = '0;
  logic        sclk_lvl = 1'b1;
  logic        mosi_lvl = 1'b0;
  logic        frame_is_read = 1'b0;
  logic        sel_chip = 1'b0;

  // Advance the tick counter; report the end of a stretch of lim ticks
  function automatic logic count_tick(input logic [7:0] lim);
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the line levels of one tick and move the shadow engine on
  function automatic res_t advance_engine(input item_t it);
    res_t r;
    logic is_cmd;
    logic cs_low;
    r = '0;
    r.busy_res = 1'b1;
    cs_low = 1'b1;
    is_cmd = it.action >= ACT_RESET && it.action <= ACT_READ3;

    // A command on an idle tick opens the frame on that same tick
    if (eng_phase == PH_IDLE) begin
      if (is_cmd) begin
        eng_phase = PH_LEAD;
        tick_cnt = '0;
        rx_shift = '0;
        read_left = '0;
        frame_is_read = 1'b0;
        case (it.action)
          ACT_RESET: begin
            tx_shift = '1;
            bits_left = 6'd32;
          end
          ACT_WRITE1: begin
            tx_shift = {it.reg_addr, it.write_data[7:0], 16'h0000};
            bits_left = 6'd16;
          end
          ACT_WRITE2: begin
            tx_shift = {it.reg_addr, it.write_data, 8'h00};
            bits_left = 6'd24;
          end
          default: begin
            tx_shift = {it.reg_addr, 24'h000000};
            bits_left = 6'd8;
            read_left = 5'(8 * (it.action - ACT_WRITE2));
            frame_is_read = 1'b1;
          end
        endcase
      end
    end else if (is_cmd) begin
      r.rejected = 1'b1;
    end

    case (eng_phase)
      PH_LEAD: begin
        sclk_lvl = 1'b1;
        if (count_tick(GUARD_TICKS)) eng_phase = PH_LOW;
      end
      PH_LOW: begin
        sclk_lvl = 1'b0;
        // Change mosi on the first low tick; hold it during the read bytes
        if (tick_cnt == 8'd0 && bits_left > 6'd0) begin
          mosi_lvl = tx_shift[31];
          tx_shift = tx_shift << 1;
        end
        if (count_tick(HALF_TICKS)) eng_phase = PH_HIGH;
      end
      PH_HIGH: begin
        sclk_lvl = 1'b1;
        if (count_tick(HALF_TICKS)) begin
          if (bits_left > 6'd0) begin
            bits_left = bits_left - 6'd1;
          end else if (read_left > 5'd0) begin
            read_left = read_left - 5'd1;
            rx_shift = {rx_shift[22:0], it.miso};
          end
          eng_phase = (bits_left == 6'd0 && read_left == 5'd0) ? PH_TRAIL : PH_LOW;
        end
      end
      PH_TRAIL: begin
        sclk_lvl = 1'b1;
        if (count_tick(GUARD_TICKS)) eng_phase = PH_DONE;
      end
      PH_DONE: begin
        sclk_lvl = 1'b1;
        cs_low = 1'b0;
        r.done_res = 1'b1;
        r.read_data = frame_is_read ? rx_shift : 24'h000000;
        eng_phase = PH_IDLE;
        tick_cnt = '0;
      end
      default: begin
        sclk_lvl = 1'b1;
        cs_low = 1'b0;
        r.busy_res = 1'b0;
        eng_phase = PH_IDLE;
      end
    endcase

    r.sclk = sclk_lvl;
    r.mosi = mosi_lvl;
    r.cs0_n = !(cs_low && sel_chip == 1'b0);
    r.cs1_n = !(cs_low && sel_chip == 1'b1);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: predict each accepted request, then offer the next one.
  // A request stays on the bus until it is taken.
  // --------------------------------------------------------------------------
  item_t cur_tick;
  int    send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_lines.push_back(advance_engine(cur_tick));
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0 && $urandom_range(0, 99) < send_gap_pct) begin
          // Start an idle burst
          send_gap = $urandom_range(0, 14);
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'b0, cur_tick.miso, cur_tick.write_data, cur_tick.reg_addr};
          in_tuser <= cur_tick.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: compare against the oldest expectation, then decide
  // whether to stall. One long hold-off fills the block so that it pushes
  // back on the request side.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  res_t got_line;
  res_t want_line;
  int   recv_stall = 0;
  bit   long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_line = out_tdata[30:0];
        responses++;
        if (expected_lines.size() == 0) begin
          $error("response 0x%0h arrived with no request outstanding", out_tdata);
          mismatches++;
        end else begin
          want_line = expected_lines.pop_front();
          check_field("sclk", 24'(want_line.sclk), 24'(got_line.sclk));
          check_field("mosi", 24'(want_line.mosi), 24'(got_line.mosi));
          check_field("cs0_n", 24'(want_line.cs0_n), 24'(got_line.cs0_n));
          check_field("cs1_n", 24'(want_line.cs1_n), 24'(got_line.cs1_n));
          check_field("busy_res", 24'(want_line.busy_res), 24'(got_line.busy_res));
          check_field("done_res", 24'(want_line.done_res), 24'(got_line.done_res));
          check_field("read_data", want_line.read_data, got_line.read_data);
          check_field("rejected", 24'(want_line.rejected), 24'(got_line.rejected));
        end
      end
      if (!long_hold_done && responses >= 600 && pending_ticks.size() > 100) begin
        long_hold_done = 1'b1;
        recv_stall = LONG_HOLD_OFF;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        recv_stall = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Queue one whole frame: the command tick, then ticks up to and including
  // the done tick. noise_pct of the later ticks carry a stray action, which the
  // engine must refuse unless it is seven; miso_mode picks zeros, ones or random miso.
  task automatic queue_frame(input logic [2:0] act, input logic [7:0] reg_byte,
                             input logic [15:0] data, input int noise_pct,
                             input int miso_mode);
    item_t it;
    int    n_bits;
    int    len;
    case (act)
      ACT_RESET:  n_bits = 32;
      ACT_WRITE1: n_bits = 16;
      ACT_WRITE2: n_bits = 24;
      default:    n_bits = 8 + 8 * (act - ACT_WRITE2);
    endcase
    len = 2 * int'(GUARD_TICKS) + 2 * int'(HALF_TICKS) * n_bits + 1;
    it.action = act;
    it.reg_addr = reg_byte;
    it.write_data = data;
    it.miso = (miso_mode == 2) ? 1'($urandom) : 1'(miso_mode);
    pending_ticks.push_back(it);
    for (int i = 1; i < len; i++) begin
      it.action = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(1, 7)) : ACT_TICK;
      it.reg_addr = 8'($urandom);
      it.write_data = 16'($urandom);
      it.miso = (miso_mode == 2) ? 1'($urandom) : 1'(miso_mode);
      pending_ticks.push_back(it);
    end
  endtask

  // Queue idle ticks; action seven must be ignored just as tick-only is
  task automatic queue_idle(input int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.action = $urandom_range(0, 3) == 0 ? 3'd7 : ACT_TICK;
      it.reg_addr = 8'($urandom);
      it.write_data = 16'($urandom);
      it.miso = 1'($urandom);
      pending_ticks.push_back(it);
    end
  endtask

  // Hold the sender until every request is answered, then let the pipeline
  // settle before any register access; look between edges so that the
  // driver's decisions at the edge have landed
  task automatic settle();
    do
      @(negedge clk);
    while (pending_ticks.size() > 0 || in_tvalid || expected_lines.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the chip select choice and read it back
  task automatic set_chip(input logic chip);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CHIP_ADDR;
    cfg_pwdata <= {31'b0, chip};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (eng_phase == PH_IDLE) sel_chip = chip;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    check_field("selected_chip", 24'(sel_chip), 24'(cfg_prdata[0]));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Well-formed frames with random content, stray commands inside them and
  // short idle stretches between them; a zero-length stretch puts the next
  // command on the first idle tick
  task automatic queue_random(input int n_ticks);
    while (pending_ticks.size() < n_ticks) begin
      queue_frame(3'($urandom_range(ACT_RESET, ACT_READ3)), 8'($urandom),
                  16'($urandom), 8, 2);
      queue_idle($urandom_range(0, 3));
    end
  endtask

  initial begin
    item_t done_tick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames framed by chip select one
    set_chip(1'b1);
    send_gap_pct = 10;
    recv_stall_pct = 10;
    queue_idle(2);
    queue_frame(ACT_RESET, 8'h00, 16'h0000, 0, 0);
    queue_frame(ACT_WRITE1, 8'hff, 16'hffff, 0, 1);
    queue_frame(ACT_WRITE2, 8'h00, 16'hffff, 0, 2);
    queue_frame(ACT_WRITE2, 8'hff, 16'h0000, 0, 0);
    queue_frame(ACT_READ1, 8'ha5, 16'h0000, 0, 1);
    queue_frame(ACT_READ2, 8'h5a, 16'hffff, 0, 0);
    // Commands in the middle of a frame must be refused
    queue_frame(ACT_READ3, 8'h3c, 16'h1234, 40, 2);
    // Drop a command onto the done tick: still busy, so refused
    done_tick = pending_ticks.pop_back();
    done_tick.action = ACT_WRITE1;
    pending_ticks.push_back(done_tick);
    // Next command lands on the very first idle tick
    queue_frame(ACT_READ3, 8'hc3, 16'h0000, 0, 1);
    queue_idle(1);
    settle();

    set_chip(1'b0);
    queue_random(230);
    settle();

    set_chip(1'b1);
    send_gap_pct = 25;
    recv_stall_pct = 25;
    queue_random(230);
    settle();

    set_chip(1'b0);
    send_gap_pct = 5;
    recv_stall_pct = 5;
    queue_random(230);
    settle();

    // Closing stretch runs flat out on both sides
    set_chip(1'b1);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    queue_random(230);
    settle();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
